/* hdl/tpd_pkg.sv */
package tpd_pkg;

  localparam int unsigned CHANNELS     = 16;
  localparam int unsigned BUFFER_BYTES = 256;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_TOO_LITTLE = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_t;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic search;     // compare one table entry
    logic alloc;      // allocate new channel
    logic ptr_rd;     // latch count and read or write pointer of chosen channel
    logic wr_byte;    // write one byte to store
    logic rd_byte;    // issue one store read
    logic cap_byte;   // capture read data
    logic commit_enq; // update count/pointer after enqueue
    logic commit_deq; // update count/pointer after dequeue
    logic emit;       // drive result
    status_t status;
  } tpd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic cmd;
    logic search_hit;
    logic search_end;
    logic table_full;
    logic no_space;
    logic len_zero;
    logic ch_unknown;
    logic too_little;
    logic last_byte;
  } tpd_stat_t;

endpackage

/* hdl/tpd_datapath.sv */
module tpd_datapath #(
  parameter int unsigned PACKET_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpd_pkg::tpd_cmd_t  ctl,
  output tpd_pkg::tpd_stat_t sts,
  input  logic               in_command,
  input  logic [7:0]         in_tag,
  input  logic [3:0]         in_channel,
  input  logic [3:0]         in_length,
  input  logic [63:0]        in_payload_in,
  output logic [2:0]         out_status,
  output logic [3:0]         out_channel_out,
  output logic [63:0]        out_payload_out,
  output logic [8:0]         out_fill_level
);

  localparam int unsigned ChW  = (tpd_pkg::CHANNELS > 1) ? $clog2(tpd_pkg::CHANNELS) : 1;
  localparam int unsigned UsedW = $clog2(tpd_pkg::CHANNELS + 1);
  localparam int unsigned PtrW = $clog2(tpd_pkg::BUFFER_BYTES);
  localparam int unsigned CntW = $clog2(tpd_pkg::BUFFER_BYTES + 1);
  localparam int unsigned AddrW = ChW + PtrW;
  localparam int unsigned Depth = tpd_pkg::CHANNELS * tpd_pkg::BUFFER_BYTES;

  // item registers
  logic            cmd_r;
  logic [7:0]      tag_r;
  logic [3:0]      chan_in_r;
  logic [3:0]      len_r;
  logic [63:0]     pay_r;
  logic [ChW-1:0]  ch_r;
  logic [ChW:0]    idx_r;
  logic [3:0]      bcnt_r;
  logic [PtrW-1:0] ptr_r;
  logic [CntW-1:0] cnt_r;
  logic [63:0]     rdpay_r;
  logic [UsedW-1:0] used_r;
  logic [7:0]      rdata_r;

  logic [7:0]      tags_r  [tpd_pkg::CHANNELS];
  logic [PtrW-1:0] rptr_r  [tpd_pkg::CHANNELS];
  logic [PtrW-1:0] wptr_r  [tpd_pkg::CHANNELS];
  logic [CntW-1:0] count_r [tpd_pkg::CHANNELS];
  logic [7:0]      store_r [Depth];

  logic [3:0]      len_sat;
  logic [ChW-1:0]  in_ch_idx;
  logic [ChW-1:0]  sidx;
  logic [CntW:0]   sum;

  assign len_sat   = (in_length > 4'(PACKET_BYTES)) ? 4'(PACKET_BYTES) : in_length;
  assign in_ch_idx = ChW'(in_channel);
  assign sidx      = idx_r[ChW-1:0];
  assign sum       = (CntW+1)'(cnt_r) + (CntW+1)'(len_r);

  // status toward controller
  always_comb begin
    sts.cmd        = cmd_r;
    sts.search_end = ((CntW+1)'(idx_r) >= (CntW+1)'(used_r));
    sts.search_hit = !sts.search_end && (tags_r[sidx] == tag_r);
    sts.table_full = (UsedW+1)'(used_r) >= (UsedW+1)'(tpd_pkg::CHANNELS);
    sts.no_space   = sum >= (CntW+1)'(tpd_pkg::BUFFER_BYTES);
    sts.len_zero   = (len_r == 4'd0);
    sts.ch_unknown = (32'(chan_in_r) >= 32'(used_r)) ||
                     (32'(chan_in_r) >= tpd_pkg::CHANNELS);
    sts.too_little = cnt_r < CntW'(PACKET_BYTES);
    sts.last_byte  = (bcnt_r + 4'd1 >= len_r);
  end

  // item capture, search index, byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      idx_r  <= '0;
    end else begin
      if (ctl.load) begin
        cmd_r     <= in_command;
        tag_r     <= in_tag;
        chan_in_r <= in_channel;
        len_r     <= (in_command == tpd_pkg::CMD_DEQ) ? 4'(PACKET_BYTES) : len_sat;
        pay_r     <= in_payload_in;
        ch_r      <= in_ch_idx;
        idx_r     <= '0;
        bcnt_r    <= '0;
        rdpay_r   <= '0;
      end
      if (ctl.search) begin
        if (sts.search_hit) ch_r <= sidx;
        else idx_r <= idx_r + 1'b1;
      end
      if (ctl.alloc) begin
        ch_r <= used_r[ChW-1:0];
        tags_r[used_r[ChW-1:0]]  <= tag_r;
        rptr_r[used_r[ChW-1:0]]  <= '0;
        wptr_r[used_r[ChW-1:0]]  <= '0;
        count_r[used_r[ChW-1:0]] <= '0;
        used_r <= used_r + 1'b1;
      end
      if (ctl.ptr_rd) begin
        cnt_r <= count_r[ch_r];
        ptr_r <= (cmd_r == tpd_pkg::CMD_DEQ) ? rptr_r[ch_r] : wptr_r[ch_r];
      end
      if (ctl.wr_byte || ctl.rd_byte) begin
        ptr_r  <= ptr_r + 1'b1;
      end
      if (ctl.wr_byte || ctl.cap_byte) bcnt_r <= bcnt_r + 4'd1;
      if (ctl.cap_byte) rdpay_r[8*bcnt_r[2:0] +: 8] <= rdata_r;
      if (ctl.commit_enq) begin
        count_r[ch_r] <= CntW'(sum);
        cnt_r         <= CntW'(sum);
        wptr_r[ch_r]  <= ptr_r;
      end
      if (ctl.commit_deq) begin
        count_r[ch_r] <= cnt_r - CntW'(PACKET_BYTES);
        cnt_r         <= cnt_r - CntW'(PACKET_BYTES);
        rptr_r[ch_r]  <= ptr_r;
      end
    end
  end

  // byte store: one write or one read a cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_byte) store_r[{ch_r, ptr_r}] <= pay_r[8*bcnt_r[2:0] +: 8];
    if (ctl.rd_byte) rdata_r <= store_r[AddrW'({ch_r, ptr_r})];
  end

  // result register, valid for one cycle under the strobe
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status <= ctl.status;
      unique case (ctl.status)
        tpd_pkg::ST_OK: begin
          out_channel_out <= 4'(ch_r);
          out_fill_level  <= 9'(cnt_r);
          out_payload_out <= (cmd_r == tpd_pkg::CMD_DEQ) ? rdpay_r : '0;
        end
        tpd_pkg::ST_NO_SPACE, tpd_pkg::ST_TOO_LITTLE: begin
          out_channel_out <= 4'(ch_r);
          out_fill_level  <= 9'(cnt_r);
          out_payload_out <= '0;
        end
        tpd_pkg::ST_UNKNOWN: begin
          out_channel_out <= chan_in_r;
          out_fill_level  <= '0;
          out_payload_out <= '0;
        end
        default: begin
          out_channel_out <= '0;
          out_fill_level  <= '0;
          out_payload_out <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/tpd_ctrl.sv */
module tpd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output tpd_pkg::tpd_cmd_t  ctl,
  input  tpd_pkg::tpd_stat_t sts
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_PTR    = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_WRITE  = 9'b000010000,
    S_READ   = 9'b000100000,
    S_CAP    = 9'b001000000,
    S_COMMIT = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  tpd_pkg::status_t st_r, st_nxt;
  logic valid_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ctl       = '0;
    ctl.status = st_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        ctl.load  = 1'b1;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.cmd == tpd_pkg::CMD_DEQ) begin
          if (sts.ch_unknown) begin
            st_nxt = tpd_pkg::ST_UNKNOWN;
            state_nxt = S_EMIT;
          end else state_nxt = S_PTR;
        end else begin
          ctl.search = 1'b1;
          if (sts.search_hit) state_nxt = S_PTR;
          else if (sts.search_end) begin
            if (sts.table_full) begin
              st_nxt = tpd_pkg::ST_TABLE_FULL;
              state_nxt = S_EMIT;
            end else begin
              ctl.search = 1'b0;
              ctl.alloc  = 1'b1;
              state_nxt  = S_PTR;
            end
          end
        end
      end
      S_PTR: begin
        ctl.ptr_rd = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        st_nxt = tpd_pkg::ST_OK;
        if (sts.cmd == tpd_pkg::CMD_DEQ) begin
          if (sts.too_little) begin
            st_nxt = tpd_pkg::ST_TOO_LITTLE;
            state_nxt = S_EMIT;
          end else state_nxt = S_READ;
        end else if (sts.no_space) begin
          st_nxt = tpd_pkg::ST_NO_SPACE;
          state_nxt = S_EMIT;
        end else if (sts.len_zero) state_nxt = S_COMMIT;
        else state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ctl.wr_byte = 1'b1;
        if (sts.last_byte) state_nxt = S_COMMIT;
      end
      S_READ: begin
        ctl.rd_byte = 1'b1;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        ctl.cap_byte = 1'b1;
        state_nxt = sts.last_byte ? S_COMMIT : S_READ;
      end
      S_COMMIT: begin
        if (sts.cmd == tpd_pkg::CMD_DEQ) ctl.commit_deq = 1'b1;
        else ctl.commit_enq = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state, strobe in the cycle after emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= tpd_pkg::ST_OK;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      valid_r <= ctl.emit;
    end
  end

endmodule

/* hdl/tagged_packet_demux_fifos.sv */
// Channel  | Ports                                            | Transfer
// input    | start, busy, in_command/tag/channel/length/payload_in | start && !busy
// result   | out_valid, out_status/channel_out/payload_out/fill_level | out_valid
//
// Enqueue searches the table entry by entry, then writes the bytes one at a time;
// dequeue reads then captures each byte in turn through the one-port byte store.
// Reset: synchronous, clears the channel table count and the controller.
// Results appear for one cycle; the receiver cannot stall. busy is high
// through the result strobe cycle.
module tagged_packet_demux_fifos #(
  parameter int unsigned PACKET_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_tag,
  input  logic [3:0]  in_channel,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_payload_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_channel_out,
  output logic [63:0] out_payload_out,
  output logic [8:0]  out_fill_level
);

  tpd_pkg::tpd_cmd_t  ctl;
  tpd_pkg::tpd_stat_t sts;
  logic               busy_c;

  // busy also covers the result cycle
  assign busy = busy_c || out_valid;

  tpd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start && !out_valid), .busy(busy_c),
    .out_valid(out_valid), .ctl(ctl), .sts(sts)
  );

  tpd_datapath #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_command(in_command), .in_tag(in_tag), .in_channel(in_channel),
    .in_length(in_length), .in_payload_in(in_payload_in),
    .out_status(out_status), .out_channel_out(out_channel_out),
    .out_payload_out(out_payload_out), .out_fill_level(out_fill_level)
  );

endmodule

/* hdl/tpd_checker.sv */
module tpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [63:0] out_payload_out,
  input logic [8:0]  out_fill_level
);

  // accepted item raises busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

  // strobe is a single cycle
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe repeated");

  // no result while idle
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // payload only on ok results
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tpd_pkg::ST_OK) |-> (out_payload_out == 64'd0))
    else $error("payload on failure");

  // fill level never exceeds 256
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_level <= 9'd256)) else $error("fill range");

endmodule

bind tagged_packet_demux_fifos tpd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_payload_out(out_payload_out),
  .out_fill_level(out_fill_level)
);

/* tb/tagged_packet_demux_fifos_test.sv */
module tagged_packet_demux_fifos_test;

  localparam int NumChannels = 16;
  localparam int FifoBytes   = 256;
  localparam int PacketBytes = 8;
  localparam int RandomItems = 880;

  // Channel table, FIFO contents and the queue of predicted transfers
  class demux_scoreboard;
    typedef struct {
      tpd_pkg::status_t status;
      logic [3:0]  channel;
      logic [63:0] payload;
      logic [8:0]  fill;
    } demux_result_t;

    demux_result_t pending[$];
    logic [7:0]    tags [NumChannels];
    int            used;
    logic [7:0]    fifo_data [NumChannels][FifoBytes];
    int            rd_ptr [NumChannels];
    int            wr_ptr [NumChannels];
    int            fill_count [NumChannels];
    int            mismatches;

    // Predict the result of one accepted command
    function void note_command(logic cmd, logic [7:0] tag, logic [3:0] chan,
                               logic [3:0] len, logic [63:0] pay);
      demux_result_t r;
      int ch;
      int n;
      bit hit;
      r.payload = '0;
      hit = 0;
      ch = 0;
      if (cmd == tpd_pkg::CMD_ENQ) begin
        // look up tag in allocation order
        for (int i = 0; i < used; i++) begin
          if (!hit && tags[i] == tag) begin
            ch = i;
            hit = 1;
          end
        end
        if (!hit && used >= NumChannels) begin
          r.status = tpd_pkg::ST_TABLE_FULL;
          r.channel = '0;
          r.fill = '0;
          pending.insert(pending.size(), r);
          return;
        end
        // allocate the next channel on a miss
        if (!hit) begin
          ch = used;
          tags[ch] = tag;
          rd_ptr[ch] = 0;
          wr_ptr[ch] = 0;
          fill_count[ch] = 0;
          used++;
        end
        n = (len > PacketBytes) ? PacketBytes : len;
        r.channel = ch[3:0];
        if (fill_count[ch] + n >= FifoBytes) begin
          r.status = tpd_pkg::ST_NO_SPACE;
        end else begin
          for (int i = 0; i < n; i++) begin
            fifo_data[ch][wr_ptr[ch]] = pay[8*i +: 8];
            wr_ptr[ch] = (wr_ptr[ch] + 1) % FifoBytes;
          end
          fill_count[ch] += n;
          r.status = tpd_pkg::ST_OK;
        end
        r.fill = fill_count[ch][8:0];
      end else begin
        ch = chan;
        r.channel = chan;
        if (ch >= used) begin
          r.status = tpd_pkg::ST_UNKNOWN;
          r.fill = '0;
        end else if (fill_count[ch] < PacketBytes) begin
          r.status = tpd_pkg::ST_TOO_LITTLE;
          r.fill = fill_count[ch][8:0];
        end else begin
          // pop one packet, first byte lowest
          for (int i = 0; i < PacketBytes; i++) begin
            r.payload[8*i +: 8] = fifo_data[ch][rd_ptr[ch]];
            rd_ptr[ch] = (rd_ptr[ch] + 1) % FifoBytes;
          end
          fill_count[ch] -= PacketBytes;
          r.status = tpd_pkg::ST_OK;
          r.fill = fill_count[ch][8:0];
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [2:0] st, logic [3:0] ch, logic [63:0] pay,
                               logic [8:0] fill);
      demux_result_t r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d channel %0d payload %h fill %0d",
                   st, ch, pay, fill);
        return;
      end
      r = pending.pop_front();
      if (st !== r.status || ch !== r.channel || pay !== r.payload || fill !== r.fill) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected status %0d channel %0d payload %h fill %0d,",
                    " got status %0d channel %0d payload %h fill %0d"},
                   r.status, r.channel, r.payload, r.fill, st, ch, pay, fill);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [7:0]  in_tag;
  logic [3:0]  in_channel;
  logic [3:0]  in_length;
  logic [63:0] in_payload_in;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_channel_out;
  logic [63:0] out_payload_out;
  logic [8:0]  out_fill_level;

  demux_scoreboard book = new();
  logic [7:0]      tag_pool [20];

  tagged_packet_demux_fifos DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_tag(in_tag), .in_channel(in_channel),
    .in_length(in_length), .in_payload_in(in_payload_in),
    .out_valid(out_valid), .out_status(out_status), .out_channel_out(out_channel_out),
    .out_payload_out(out_payload_out), .out_fill_level(out_fill_level)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      book.check_result(out_status, out_channel_out, out_payload_out, out_fill_level);
  end

  // Present one command from a falling edge and hold it until transferred
  task automatic send(input logic cmd, input logic [7:0] tag, input logic [3:0] chan,
                      input logic [3:0] len, input logic [63:0] pay);
    start = 1'b1;
    in_command = cmd;
    in_tag = tag;
    in_channel = chan;
    in_length = len;
    in_payload_in = pay;
    do @(posedge clk); while (busy !== 1'b0);
    book.note_command(cmd, tag, chan, len, pay);
    @(negedge clk);
  endtask

  // Drop start for a random burst of cycles
  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 15);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_payload();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    #5_000_000;
    $display("tagged_packet_demux_fifos_test failed");
    $finish;
  end

  initial begin
    int enq_pct;
    int drain;
    logic        cmd;
    logic [7:0]  tag;
    logic [3:0]  chan;
    logic [3:0]  len;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = tpd_pkg::CMD_ENQ;
    in_tag = '0;
    in_channel = '0;
    in_length = '0;
    in_payload_in = '0;
    for (int i = 0; i < 20; i++) tag_pool[i] = $urandom_range(0, 255);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unknown channels, zero and oversize lengths, short and full packets
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd0, 4'd0, '0);
    send(tpd_pkg::CMD_DEQ, 8'hff, 4'd15, 4'd15, '1);
    send(tpd_pkg::CMD_ENQ, 8'h00, 4'd0, 4'd0, '0);
    send(tpd_pkg::CMD_ENQ, 8'h00, 4'd15, 4'd1, '1);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd0, 4'd1, '0);
    send(tpd_pkg::CMD_ENQ, 8'hff, 4'd0, 4'd8, '1);
    idle_burst();
    send(tpd_pkg::CMD_ENQ, 8'hff, 4'd0, 4'd15, 64'h0123_4567_89ab_cdef);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd1, 4'd0, '0);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd1, 4'd0, '0);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd1, 4'd0, '0);
    send(tpd_pkg::CMD_ENQ, 8'h00, 4'd0, 4'd8, rand_payload());
    send(tpd_pkg::CMD_ENQ, 8'h00, 4'd0, 4'd7, rand_payload());
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd0, 4'd0, '0);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd0, 4'd0, '0);
    send(tpd_pkg::CMD_DEQ, 8'h00, 4'd2, 4'd0, '0);
    send(tpd_pkg::CMD_ENQ, 8'h5a, 4'd0, 4'd9, rand_payload());

    // Random: hot tags fill a few FIFOs past wraparound, extra tags exhaust the table
    enq_pct = 60;
    for (int k = 0; k < RandomItems; k++) begin
      if (k % 100 == 0) enq_pct = $urandom_range(25, 90);
      cmd = ($urandom_range(0, 99) < enq_pct) ? tpd_pkg::CMD_ENQ : tpd_pkg::CMD_DEQ;
      if ($urandom_range(0, 99) < 15) tag = $urandom_range(0, 255);
      else if ($urandom_range(0, 1)) tag = tag_pool[$urandom_range(0, 2)];
      else tag = tag_pool[$urandom_range(0, 19)];
      if (book.used > 0 && $urandom_range(0, 99) < 85)
        chan = $urandom_range(0, book.used - 1);
      else
        chan = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 8);
      else len = $urandom_range(0, 15);
      send(cmd, tag, chan, len, rand_payload());
      if (k < RandomItems - 100 && $urandom_range(0, 99) < 20) idle_burst();
    end
    start = 1'b0;

    // Drain outstanding results, then allow the block to settle
    drain = 0;
    while (book.pending.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("tagged_packet_demux_fifos_test passed");
    end else begin
      $display("tagged_packet_demux_fifos_test failed");
    end
    $finish;
  end
endmodule
